// File: hw/rtl/wcg_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, the front-to-back beat type and the cosine table function.
package wcg_pkg;

	localparam int LEN_W     = 13;
	localparam int SHAPE_W   = 3;
	localparam int IDX_W     = 12;
	localparam int COEF_W    = 16;
	localparam int REG_IDX_W = 1;

	localparam int MAX_LENGTH_DEF = 4096;
	localparam int COS_DEPTH_DEF  = 1024;

	localparam int Q_DEPTH = 4;

	// long division: quotient bits, divisor and numerator widths
	localparam int QW    = 17;
	localparam int DV_W  = 2 * LEN_W + 2;
	localparam int NUM_W = DV_W + QW;
	localparam int ROM_W = 17;

	localparam int TRI_SHIFT = 18;
	localparam int TAP_SHIFT = 17;

	localparam logic [REG_IDX_W-1:0] REG_SHAPE  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 1'd1;

	localparam logic [SHAPE_W-1:0] SHAPE_TRI  = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_HAM  = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_HANN = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_QUAD = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_ABS  = 3'd4;

	typedef logic [2:0] op_t;
	localparam op_t OP_ERR  = 3'd0;
	localparam op_t OP_ONE  = 3'd1;
	localparam op_t OP_ZERO = 3'd2;
	localparam op_t OP_TRI  = 3'd3;
	localparam op_t OP_HAM  = 3'd4;
	localparam op_t OP_HANN = 3'd5;
	localparam op_t OP_QUAD = 3'd6;
	localparam op_t OP_ABS  = 3'd7;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] d;
		logic [LEN_W:0]   big_d;
		logic [LEN_W-1:0] t;
		logic [LEN_W-1:0] x;
	} item_t;

	// hamming: floor((3538944 + 50 - 46c) / 100) via reciprocal
	localparam int HAM_BIAS  = 3538994;
	localparam int HAM_SCALE = 46;
	localparam int HAM_W     = 23;
	localparam logic [23:0] HAM_RECIP = 24'd10737419;
	localparam int HAM_SHIFT = 30;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

	// cos in Q16 from an angle in Q30, the constant and ten truncated Taylor terms
	function automatic logic [ROM_W-1:0] cos_entry(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] acc;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		acc = signed'(term);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) != 0) begin
				acc = acc - signed'(term);
			end else begin
				acc = acc + signed'(term);
			end
		end
		if (acc < 0) begin
			acc = 64'sd0;
		end
		r = (unsigned'(acc) + 64'd8192) >> 14;
		if (r > 64'd65536) begin
			r = 64'd65536;
		end
		return r[ROM_W-1:0];
	endfunction

endpackage

// File: hw/rtl/wcg_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/wcg_front.sv
`timescale 1ns / 1ps
// Front end: takes index beats, classifies them and forms the shared terms.
module wcg_front #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [wcg_pkg::IDX_W-1:0]     sample_index,
	input  logic [wcg_pkg::SHAPE_W-1:0]   shape,
	input  logic [wcg_pkg::LEN_W-1:0]     length,
	input  logic                          init_done,
	input  logic                          q_full,
	output logic                          q_push,
	output wcg_pkg::item_t                q_item
);
	import wcg_pkg::*;

	logic             accept;
	logic             adv;
	logic [LEN_W-1:0] n;
	logic [LEN_W-1:0] i_ext;
	logic [LEN_W-1:0] two_i;
	item_t            item_d;
	item_t            item_s1;
	logic             v_s1;

	always_comb begin
		n = (32'(length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : length;
		i_ext = LEN_W'(sample_index);
		two_i = {sample_index, 1'b0};
		item_d.idx = sample_index;
		item_d.d = n - 1'b1;
		item_d.big_d = {1'b0, n} + 1'b1;
		item_d.t = (two_i > item_d.d) ? two_i - item_d.d : item_d.d - two_i;
		item_d.x = (i_ext <= (item_d.d >> 1)) ? i_ext : item_d.d - i_ext;
		if (i_ext >= n) begin
			item_d.op = OP_ERR;
		end else if (n == LEN_W'(1)) begin
			item_d.op = (shape <= SHAPE_ABS) ? OP_ONE : OP_ZERO;
		end else begin
			unique case (shape)
				SHAPE_TRI:  item_d.op = OP_TRI;
				SHAPE_HAM:  item_d.op = OP_HAM;
				SHAPE_HANN: item_d.op = OP_HANN;
				SHAPE_QUAD: item_d.op = OP_QUAD;
				SHAPE_ABS:  item_d.op = OP_ABS;
				default:    item_d.op = OP_ZERO;
			endcase
		end
	end

	assign adv    = !v_s1 || !q_full;
	assign full   = !init_done || (v_s1 && q_full);
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: hw/rtl/wcg_queue.sv
`timescale 1ns / 1ps
// Short queue between front and back ends.
module wcg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wcg_pkg::item_t din,
	output logic           full,
	input  logic           pop,
	output wcg_pkg::item_t dout,
	output logic           empty
);
	import wcg_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	item_t          mem_q [Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: hw/rtl/wcg_back.sv
`timescale 1ns / 1ps
// Back end: cosine table load, pipelined long division and coefficient shaping.
module wcg_back #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  wcg_pkg::item_t               q_item,
	output logic                         q_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [wcg_pkg::COEF_W-1:0]   coefficient,
	output logic                         index_error,
	output logic                         init_done
);
	import wcg_pkg::*;

	localparam int AW     = $clog2(DEPTH + 1);
	localparam int SQ_W   = 2 * (LEN_W + 1);
	localparam logic [QW-1:0] D1 = QW'(DEPTH);
	localparam logic [QW-1:0] D2 = QW'(2 * DEPTH);
	localparam logic [QW-1:0] D3 = QW'(3 * DEPTH);
	localparam logic [QW-1:0] D4 = QW'(4 * DEPTH);

	logic en;

	// cosine table load after reset
	logic [ROM_W-1:0] cos_tbl [DEPTH+1];
	logic [AW-1:0]    init_cnt_q;
	logic             init_done_q;

	for (genvar g = 0; g <= DEPTH; g++) begin : g_tbl
		localparam logic [63:0] XQ =
			(HALF_PI_Q30 * 64'(g) + 64'(DEPTH / 2)) / 64'(DEPTH);
		assign cos_tbl[g] = cos_entry(XQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q  <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			if (init_cnt_q == AW'(DEPTH)) begin
				init_done_q <= 1'b1;
			end else begin
				init_cnt_q <= init_cnt_q + 1'b1;
			end
		end
	end

	assign init_done = init_done_q;

	// s2: squares
	logic              v_s2;
	item_t             it_s2;
	logic [SQ_W-1:0]   dd_s2;
	logic [SQ_W-1:0]   tt_s2;

	// s3 / divider
	logic [NUM_W-1:0]  num_d;
	logic [DV_W-1:0]   div_d;
	logic [NUM_W-1:0]  acc_sd [QW+1];
	logic [DV_W-1:0]   div_sd [QW+1];
	op_t               op_sd  [QW+1];
	logic              v_sd   [QW+1];

	// s4
	logic [QW-1:0]     quo;
	logic [QW-1:0]     p0;
	logic [QW-1:0]     r;
	logic [AW-1:0]     raddr;
	logic              neg_d;
	logic              v_s4;
	op_t               op_s4;
	logic              neg_s4;
	logic [COEF_W-1:0] sat_s4;
	logic [ROM_W-1:0]  rom_s4;

	// s5
	logic signed [ROM_W:0]     c;
	logic signed [HAM_W+1:0]   ham_full;
	logic [ROM_W:0]            hann_sum;
	logic [COEF_W-1:0]         val_d;
	logic              v_s5;
	op_t               op_s5;
	logic [HAM_W-1:0]  ham_s5;
	logic [COEF_W-1:0] val_s5;

	// s6 output
	logic [HAM_W+23:0] ham_prod;
	logic [HAM_W-1:0]  ham_q;
	logic              v_s6;
	logic [COEF_W-1:0] coef_s6;
	logic              err_s6;

	assign en    = !v_s6 || pop;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_sd[0] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= !q_empty;
			v_sd[0] <= v_s2;
			v_s4 <= v_sd[QW];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= q_item;
			dd_s2 <= q_item.big_d * q_item.big_d;
			tt_s2 <= SQ_W'(q_item.t) * SQ_W'(q_item.t);
		end
	end

	always_comb begin
		num_d = '0;
		div_d = DV_W'(1);
		case (it_s2.op)
			OP_TRI: begin
				num_d = (NUM_W'(it_s2.x) << TRI_SHIFT) + NUM_W'(it_s2.d);
				div_d = DV_W'(it_s2.d) << 1;
			end
			OP_HAM, OP_HANN: begin
				num_d = NUM_W'(it_s2.idx) * NUM_W'(8 * DEPTH) + NUM_W'(it_s2.d);
				div_d = DV_W'(it_s2.d) << 1;
			end
			OP_QUAD: begin
				num_d = (NUM_W'(dd_s2 - tt_s2) << TAP_SHIFT) + NUM_W'(dd_s2);
				div_d = DV_W'(dd_s2) << 1;
			end
			OP_ABS: begin
				num_d = (NUM_W'(it_s2.big_d - (LEN_W + 1)'(it_s2.t)) << TAP_SHIFT)
					+ NUM_W'(it_s2.big_d);
				div_d = DV_W'(it_s2.big_d) << 1;
			end
			default: begin
				num_d = '0;
				div_d = DV_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_sd[0] <= num_d;
			div_sd[0] <= div_d;
			op_sd[0]  <= it_s2.op;
		end
	end

	// one quotient bit per stage; remainder on top, quotient shifts in below
	for (genvar s = 0; s < QW; s++) begin : g_div
		logic [DV_W:0]   trial;
		logic [DV_W:0]   diff;
		logic            qbit;
		logic [DV_W-1:0] rem_n;

		always_comb begin
			trial = {acc_sd[s][NUM_W-1:QW], acc_sd[s][QW-1]};
			diff  = trial - {1'b0, div_sd[s]};
			qbit  = (trial >= {1'b0, div_sd[s]});
			rem_n = qbit ? diff[DV_W-1:0] : trial[DV_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[s+1] <= 1'b0;
			end else if (en) begin
				v_sd[s+1] <= v_sd[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_sd[s+1] <= {rem_n, acc_sd[s][QW-2:0], qbit};
				div_sd[s+1] <= div_sd[s];
				op_sd[s+1]  <= op_sd[s];
			end
		end
	end

	// phase to quadrant and table address
	always_comb begin
		quo = acc_sd[QW][QW-1:0];
		p0  = (quo >= D4) ? quo - D4 : quo;
		if (p0 < D1) begin
			r = p0;
			neg_d = 1'b0;
			raddr = AW'(r);
		end else if (p0 < D2) begin
			r = p0 - D1;
			neg_d = 1'b1;
			raddr = AW'(D1 - r);
		end else if (p0 < D3) begin
			r = p0 - D2;
			neg_d = 1'b1;
			raddr = AW'(r);
		end else begin
			r = p0 - D3;
			neg_d = 1'b0;
			raddr = AW'(D1 - r);
		end
	end

	wcg_ram #(
		.WIDTH(ROM_W),
		.DEPTH(DEPTH + 1)
	) u_cos_ram (
		.clk   (clk),
		.we    (!init_done_q),
		.waddr (init_cnt_q),
		.wdata (cos_tbl[init_cnt_q]),
		.re    (en),
		.raddr (raddr),
		.rdata (rom_s4)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4  <= op_sd[QW];
			neg_s4 <= neg_d;
			sat_s4 <= (quo > QW'(16'hFFFF)) ? 16'hFFFF : quo[COEF_W-1:0];
		end
	end

	always_comb begin
		c = neg_s4 ? -signed'({1'b0, rom_s4}) : signed'({1'b0, rom_s4});
		ham_full = (HAM_W + 2)'(HAM_BIAS) - (HAM_W + 2)'(HAM_SCALE) * (HAM_W + 2)'(c);
		hann_sum = (ROM_W + 1)'(65537) - unsigned'(c);
		case (op_s4)
			OP_HANN: val_d = hann_sum[ROM_W:1] > (ROM_W)'(16'hFFFF) ? 16'hFFFF
				: hann_sum[COEF_W:1];
			OP_ONE:  val_d = 16'hFFFF;
			OP_TRI, OP_QUAD, OP_ABS: val_d = sat_s4;
			default: val_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s5  <= op_s4;
			ham_s5 <= ham_full[HAM_W-1:0];
			val_s5 <= val_d;
		end
	end

	always_comb begin
		ham_prod = (HAM_W + 24)'(ham_s5) * (HAM_W + 24)'(HAM_RECIP);
		ham_q    = HAM_W'(ham_prod >> HAM_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s6 <= (op_s5 == OP_ERR);
			if (op_s5 == OP_HAM) begin
				coef_s6 <= (ham_q > HAM_W'(16'hFFFF)) ? 16'hFFFF : ham_q[COEF_W-1:0];
			end else begin
				coef_s6 <= val_s5;
			end
		end
	end

	assign empty       = !v_s6;
	assign coefficient = coef_s6;
	assign index_error = err_s6;

endmodule

// File: hw/rtl/window_coefficient_generator.sv
`timescale 1ns / 1ps
// Window coefficient generator top level: configuration registers and block wiring.
// Takes one sample index per cycle while full is low and returns its window coefficient in
// unsigned Q0.16, in order; the rate is one beat per cycle unless pop holds the output,
// carried by a 17-stage one-bit-per-stage long divider and a registered cosine table read.
// After reset the quarter-wave cosine RAM is loaded with COS_TABLE_DEPTH+1 entries;
// full stays high during the load, and configuration writes are taken at any time.
module window_coefficient_generator #(
	parameter int MAX_LENGTH      = wcg_pkg::MAX_LENGTH_DEF,
	parameter int COS_TABLE_DEPTH = wcg_pkg::COS_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [wcg_pkg::IDX_W-1:0]        sample_index,
	output logic                             empty,
	input  logic                             pop,
	output logic [wcg_pkg::COEF_W-1:0]       coefficient,
	output logic                             index_error,
	input  logic                             wr_en,
	input  logic [wcg_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [wcg_pkg::LEN_W-1:0]        wr_data
);
	import wcg_pkg::*;

	logic [SHAPE_W-1:0] shape_q;
	logic [LEN_W-1:0]   length_q;
	logic               init_done;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	item_t              f_item;
	item_t              b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= SHAPE_HAM;
			length_q <= LEN_W'(256);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHAPE:  shape_q  <= wr_data[SHAPE_W-1:0];
				REG_LENGTH: length_q <= wr_data;
				default:    ;
			endcase
		end
	end

	wcg_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_index (sample_index),
		.shape        (shape_q),
		.length       (length_q),
		.init_done    (init_done),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (f_item)
	);

	wcg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (f_item),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (b_item),
		.empty  (q_empty)
	);

	wcg_back #(
		.DEPTH(COS_TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (b_item),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.coefficient (coefficient),
		.index_error (index_error),
		.init_done   (init_done)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && index_error) |-> (coefficient == '0))
		else $error("index error beat with nonzero coefficient");

	a_no_result_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> (empty && q_empty))
		else $error("work in flight during cosine table load");

	a_load_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		$past(init_done) |-> init_done)
		else $error("table load restarted without reset");

endmodule

// File: tb/tb_window_coefficient_generator.sv
`timescale 1ns / 1ps
// Testbench for the window coefficient generator: directed table, then randomized beats checked against a window predictor.
module tb_window_coefficient_generator;
	import wcg_pkg::*;

	localparam int                 CYCLE_LIMIT = 200000;
	localparam int                 LATENCY     = 40;
	localparam int                 HOLD_CYCLES = 400;
	localparam int                 TBL_DEPTH   = 1024;
	localparam int                 LEN_CAP     = 4096;
	localparam logic [63:0]        HALF_PI_FX  = 64'd1686629713;
	localparam logic [SHAPE_W-1:0] SHAPE_RSV5  = 3'd5;
	localparam logic [SHAPE_W-1:0] SHAPE_RSV6  = 3'd6;
	localparam logic [SHAPE_W-1:0] SHAPE_RSV7  = 3'd7;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              err;
	} coef_beat_t;

	typedef struct {
		logic [SHAPE_W-1:0] shape;
		logic [LEN_W-1:0]   len;
		logic [IDX_W-1:0]   idx;
		bit                 typed;
		coef_beat_t         want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [IDX_W-1:0]  sample_index;
	logic              empty;
	logic              pop;
	logic [COEF_W-1:0] coefficient;
	logic              index_error;
	logic              wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [LEN_W-1:0]  wr_data;

	window_coefficient_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_index (sample_index),
		.empty        (empty),
		.pop          (pop),
		.coefficient  (coefficient),
		.index_error  (index_error),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	longint             cos_rom [0:TBL_DEPTH];
	coef_beat_t         pending_coefs [$];
	logic [SHAPE_W-1:0] cur_shape;
	logic [LEN_W-1:0]   cur_len;
	int                 tx_idle_pct;
	int                 rx_idle_pct;
	int                 mismatches;
	int                 beats_checked;
	int                 beats_sent;
	int                 cfg_writes;
	int                 cycles;
	bit                 hold_tog;
	bit                 hold_seen;
	int                 hold_cnt;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// cos(pi/2 * k/depth) in Q16, the constant and ten truncated Taylor terms on a Q30 angle
	function automatic longint quarter_cos(int k);
		logic [63:0] ang;
		logic [63:0] ang2;
		logic [63:0] term;
		logic [63:0] rnd;
		longint      acc;
		ang = (HALF_PI_FX * k + TBL_DEPTH / 2) / TBL_DEPTH;
		ang2 = (ang * ang) >> 30;
		term = 64'd1 << 30;
		acc = longint'(term);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
			acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		rnd = (64'(acc) + 64'd8192) >> 14;
		if (rnd > 64'd65536) rnd = 64'd65536;
		return longint'(rnd);
	endfunction

	function automatic longint cos_turn(logic [63:0] i, logic [63:0] d);
		logic [63:0] ph;
		logic [63:0] k;
		ph = ((64'd8 * TBL_DEPTH * i + d) / (64'd2 * d)) % (4 * TBL_DEPTH);
		k = ph % TBL_DEPTH;
		case (ph / TBL_DEPTH)
			0: return cos_rom[k];
			1: return -cos_rom[TBL_DEPTH - k];
			2: return -cos_rom[k];
			default: return cos_rom[TBL_DEPTH - k];
		endcase
	endfunction

	function automatic coef_beat_t window_value(logic [SHAPE_W-1:0] shp, logic [LEN_W-1:0] len,
			logic [IDX_W-1:0] idx);
		logic [63:0] n;
		logic [63:0] i;
		logic [63:0] d;
		logic [63:0] bd;
		logic [63:0] t;
		logic [63:0] x;
		logic [63:0] v;
		longint      c;
		coef_beat_t  r;
		r = '0;
		i = idx;
		n = len;
		if (n > LEN_CAP) n = LEN_CAP;
		if (i >= n) begin
			r.err = 1'b1;
			return r;
		end
		if (n == 1) begin
			r.coef = (shp <= SHAPE_ABS) ? 16'hFFFF : 16'h0;
			return r;
		end
		d = n - 1;
		bd = n + 1;
		t = (2 * i > d) ? 2 * i - d : d - 2 * i;
		v = 0;
		case (shp)
			SHAPE_TRI: begin
				x = (i <= d / 2) ? i : d - i;
				v = (64'd262144 * x + d) / (2 * d);
			end
			SHAPE_HAM: begin
				c = cos_turn(i, d);
				v = 64'((longint'(3538944) - 46 * c + 50) / 100);
			end
			SHAPE_HANN: begin
				c = cos_turn(i, d);
				v = 64'((longint'(65536) - c + 1) / 2);
			end
			SHAPE_QUAD: v = (64'd131072 * (bd * bd - t * t) + bd * bd) / (2 * bd * bd);
			SHAPE_ABS:  v = (64'd131072 * (bd - t) + bd) / (2 * bd);
			default:    v = 0;
		endcase
		r.coef = (v > 64'd65535) ? 16'hFFFF : v[15:0];
		return r;
	endfunction

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles,
				pending_coefs.size());
			$display("FAIL");
			$finish;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result side
	always @(posedge clk) begin
		coef_beat_t want;
		if (arst_n && pop && !empty) begin
			if (pending_coefs.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected beat: coef=%0d err=%0b", coefficient, index_error);
			end else begin
				want = pending_coefs.pop_front();
				beats_checked <= beats_checked + 1;
				if (want.coef !== coefficient || want.err !== index_error) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch beat %0d: exp coef=%0d err=%0b, got coef=%0d err=%0b",
							beats_checked, want.coef, want.err, coefficient, index_error);
				end
			end
		end
		pop <= arst_n && hold_cnt == 0 && hold_tog == hold_seen
			&& $urandom_range(99) >= rx_idle_pct;
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] sel, logic [LEN_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= sel;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_writes++;
		if (sel == REG_SHAPE) cur_shape = val[SHAPE_W-1:0];
		else cur_len = val;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_coefs.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic configure(logic [SHAPE_W-1:0] shp, logic [LEN_W-1:0] len);
		if (shp == cur_shape && len == cur_len) return;
		drain();
		// upper data bits are don't-care for the shape register
		write_reg(REG_SHAPE, {10'($urandom), shp});
		write_reg(REG_LENGTH, len);
	endtask

	task automatic send_beat(logic [IDX_W-1:0] idx, bit typed, coef_beat_t want);
		coef_beat_t pred;
		push <= 1'b1;
		sample_index <= idx;
		do @(posedge clk); while (full);
		pred = window_value(cur_shape, cur_len, idx);
		if (typed && pred !== want)
			$display("note: table row idx=%0d disagrees with predictor", idx);
		pending_coefs.push_back(typed ? want : pred);
		beats_sent++;
		if ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(9))
			0: return 13'd1;
			1: return 13'd2;
			2: return 13'd4096;
			3: return 13'(8191);
			4: return 13'(4097);
			5: return 13'($urandom_range(8191));
			6: return 13'($urandom_range(4096, 2));
			default: return 13'($urandom_range(64, 2));
		endcase
	endfunction

	task automatic random_run(int count, bit pressure);
		logic [SHAPE_W-1:0] shp;
		logic [LEN_W-1:0]   len;
		int                 lim;
		for (int k = 0; k < count; k++) begin
			if (k % 80 == 0) begin
				shp = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
					: 3'($urandom_range(4));
				configure(shp, pick_length());
				if (pressure && k == 80) hold_tog = ~hold_tog;
			end
			lim = (cur_len > LEN_CAP) ? LEN_CAP : cur_len;
			if (lim == 0 || $urandom_range(9) == 0)
				send_beat(12'($urandom), 1'b0, '0);
			else
				send_beat(12'($urandom_range(lim - 1)), 1'b0, '0);
		end
	endtask

	dir_row_t dir_rows [] = '{
		'{SHAPE_HAM,  13'd256,  12'd0,    1'b0, '0},
		'{SHAPE_HAM,  13'd256,  12'd128,  1'b0, '0},
		'{SHAPE_HAM,  13'd256,  12'd255,  1'b0, '0},
		'{SHAPE_HAM,  13'd256,  12'd256,  1'b1, '{16'd0, 1'b1}},
		'{SHAPE_HAM,  13'd256,  12'd4095, 1'b1, '{16'd0, 1'b1}},
		'{SHAPE_TRI,  13'd1,    12'd0,    1'b1, '{16'hFFFF, 1'b0}},
		'{SHAPE_HAM,  13'd1,    12'd0,    1'b1, '{16'hFFFF, 1'b0}},
		'{SHAPE_HANN, 13'd1,    12'd0,    1'b1, '{16'hFFFF, 1'b0}},
		'{SHAPE_QUAD, 13'd1,    12'd0,    1'b1, '{16'hFFFF, 1'b0}},
		'{SHAPE_ABS,  13'd1,    12'd0,    1'b1, '{16'hFFFF, 1'b0}},
		'{SHAPE_ABS,  13'd1,    12'd1,    1'b1, '{16'd0, 1'b1}},
		'{SHAPE_ABS,  13'd0,    12'd0,    1'b1, '{16'd0, 1'b1}},
		'{SHAPE_TRI,  13'd2,    12'd0,    1'b1, '{16'd0, 1'b0}},
		'{SHAPE_TRI,  13'd2,    12'd1,    1'b0, '0},
		'{SHAPE_RSV5, 13'd16,   12'd3,    1'b1, '{16'd0, 1'b0}},
		'{SHAPE_RSV6, 13'd16,   12'd3,    1'b1, '{16'd0, 1'b0}},
		'{SHAPE_RSV7, 13'd16,   12'd3,    1'b1, '{16'd0, 1'b0}},
		'{SHAPE_RSV7, 13'd16,   12'd16,   1'b1, '{16'd0, 1'b1}},
		'{SHAPE_TRI,  13'd4096, 12'd2047, 1'b0, '0},
		'{SHAPE_HANN, 13'd4096, 12'd2048, 1'b0, '0},
		'{SHAPE_HAM,  13'd4096, 12'd4095, 1'b0, '0},
		'{SHAPE_QUAD, 13'd8191, 12'd4095, 1'b0, '0},
		'{SHAPE_ABS,  13'd8191, 12'd0,    1'b0, '0},
		'{SHAPE_TRI,  13'd4097, 12'd4095, 1'b0, '0},
		'{SHAPE_HANN, 13'd3,    12'd1,    1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample_index = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cycles = 0;
		mismatches = 0;
		beats_checked = 0;
		beats_sent = 0;
		cfg_writes = 0;
		hold_tog = 1'b0;
		hold_seen = 1'b0;
		hold_cnt = 0;
		cur_shape = SHAPE_HAM;
		cur_len = 13'd256;
		tx_idle_pct = 9;
		rx_idle_pct = 53;
		for (int k = 0; k <= TBL_DEPTH; k++) cos_rom[k] = quarter_cos(k);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			configure(dir_rows[r].shape, dir_rows[r].len);
			send_beat(dir_rows[r].idx, dir_rows[r].typed, dir_rows[r].want);
		end

		random_run(540, 1'b1);
		drain();
		tx_idle_pct = 53;
		rx_idle_pct = 9;
		random_run(540, 1'b0);
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_run(540, 1'b0);
		drain();

		$display("covered %0d index beats (%0d checked) over %0d register writes,",
			beats_sent, beats_checked, cfg_writes);
		$display("all five shapes, reserved codes, out-of-window and clamped lengths");
		if (mismatches == 0 && pending_coefs.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule
